>>> src/sclf_pkg.sv
// ----------------------------------------------------------------------------
// sclf_pkg
// Shared types, op codes, flag bit positions and range limits for the
// saturating clamp and flag unit.
// ----------------------------------------------------------------------------
package sclf_pkg;

  localparam int unsigned FLAG_W  = 18;
  localparam int unsigned SHAPE_W = 44;

  localparam logic [2:0] OP_MAC123 = 3'd0;
  localparam logic [2:0] OP_MAC0   = 3'd1;
  localparam logic [2:0] OP_IR123  = 3'd2;
  localparam logic [2:0] OP_IR0    = 3'd3;
  localparam logic [2:0] OP_SZ3    = 3'd4;
  localparam logic [2:0] OP_RGB    = 3'd5;
  localparam logic [2:0] OP_SXY2   = 3'd6;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam logic [1:0] CH_NONE = 2'd0;
  localparam logic [1:0] CH_1    = 2'd1;
  localparam logic [1:0] CH_2    = 2'd2;
  localparam logic [1:0] CH_3    = 2'd3;

  localparam logic [4:0] FB_MACP  = 5'd0;
  localparam logic [4:0] FB_MACN  = 5'd3;
  localparam logic [4:0] FB_IR    = 5'd6;
  localparam logic [4:0] FB_RGB   = 5'd9;
  localparam logic [4:0] FB_SZ3   = 5'd12;
  localparam logic [4:0] FB_MAC0P = 5'd13;
  localparam logic [4:0] FB_MAC0N = 5'd14;
  localparam logic [4:0] FB_SX2   = 5'd15;
  localparam logic [4:0] FB_IR0   = 5'd17;

  localparam logic signed [63:0] MAC_MAX  = 64'sh0000_07FF_FFFF_FFFF;
  localparam logic signed [63:0] MAC_MIN  = -64'sh0000_0800_0000_0000;
  localparam logic signed [63:0] MAC0_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] MAC0_MIN = -64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] IR_MAX   = 64'sh7FFF;
  localparam logic signed [63:0] IR_MIN   = -64'sh8000;
  localparam logic signed [63:0] IR0_MAX  = 64'sh1000;
  localparam logic signed [63:0] SZ3_MAX  = 64'shFFFF;
  localparam logic signed [63:0] RGB_MAX  = 64'shFF;
  localparam logic signed [63:0] SXY_MAX  = 64'sh3FF;
  localparam logic signed [63:0] SXY_MIN  = -64'sh400;
  localparam logic signed [63:0] ZERO     = 64'sh0;

  typedef struct packed {
    logic [2:0]         op;
    logic [1:0]         index;
    logic signed [63:0] value;
    logic               lm;
    logic               clear_first;
  } req_t;

  typedef struct packed {
    logic signed [SHAPE_W-1:0] shaped_value;
    logic [FLAG_W-1:0]         flag_word;
    logic                      saturated;
  } rsp_t;

endpackage

>>> src/sclf_check.sv
// ----------------------------------------------------------------------------
// sclf_check
// Range check and shaping of one request against the current sticky flags;
// returns the response with the updated flag word.
// ----------------------------------------------------------------------------
module sclf_check (
  input  sclf_pkg::req_t                    req,
  input  logic [sclf_pkg::FLAG_W-1:0]       flags,
  output sclf_pkg::rsp_t                    rsp
);

  function automatic logic [sclf_pkg::FLAG_W-1:0] chan_flag(
    input logic [4:0] base,
    input logic [1:0] idx
  );
    logic [sclf_pkg::FLAG_W-1:0] f;
    f = '0;
    case (idx)
      sclf_pkg::CH_1: f = sclf_pkg::FLAG_W'(1) << base;
      sclf_pkg::CH_2: f = sclf_pkg::FLAG_W'(1) << (base + 5'd1);
      sclf_pkg::CH_3: f = sclf_pkg::FLAG_W'(1) << (base + 5'd2);
      default:        f = '0;
    endcase
    return f;
  endfunction

  logic signed [63:0]          v;
  logic signed [63:0]          lo;
  logic signed [63:0]          hi;
  logic signed [63:0]          clamped;
  logic                        below;
  logic                        above;
  logic [sclf_pkg::FLAG_W-1:0] base_flags;
  logic [sclf_pkg::FLAG_W-1:0] set_flags;
  logic [sclf_pkg::SHAPE_W-1:0] shaped;

  assign v          = req.value;
  assign base_flags = req.clear_first ? '0 : flags;

  // limits per op; mac ops use their own wrap limits
  always_comb begin
    lo = sclf_pkg::ZERO;
    hi = sclf_pkg::ZERO;
    case (req.op)
      sclf_pkg::OP_MAC123: begin
        lo = sclf_pkg::MAC_MIN;
        hi = sclf_pkg::MAC_MAX;
      end
      sclf_pkg::OP_MAC0: begin
        lo = sclf_pkg::MAC0_MIN;
        hi = sclf_pkg::MAC0_MAX;
      end
      sclf_pkg::OP_IR123: begin
        lo = req.lm ? sclf_pkg::ZERO : sclf_pkg::IR_MIN;
        hi = sclf_pkg::IR_MAX;
      end
      sclf_pkg::OP_IR0:  hi = sclf_pkg::IR0_MAX;
      sclf_pkg::OP_SZ3:  hi = sclf_pkg::SZ3_MAX;
      sclf_pkg::OP_RGB:  hi = sclf_pkg::RGB_MAX;
      sclf_pkg::OP_SXY2: begin
        lo = sclf_pkg::SXY_MIN;
        hi = sclf_pkg::SXY_MAX;
      end
      default: begin
        lo = sclf_pkg::ZERO;
        hi = sclf_pkg::ZERO;
      end
    endcase
  end

  assign below   = v < lo;
  assign above   = v > hi;
  assign clamped = below ? lo : (above ? hi : v);

  always_comb begin
    set_flags = '0;
    shaped    = clamped[sclf_pkg::SHAPE_W-1:0];
    case (req.op)
      sclf_pkg::OP_MAC123: begin
        shaped = v[sclf_pkg::SHAPE_W-1:0];
        if (below) set_flags = chan_flag(sclf_pkg::FB_MACN, req.index);
        if (above) set_flags = chan_flag(sclf_pkg::FB_MACP, req.index);
      end
      sclf_pkg::OP_MAC0: begin
        shaped = {{(sclf_pkg::SHAPE_W-32){v[31]}}, v[31:0]};
        if (below) set_flags[sclf_pkg::FB_MAC0N] = 1'b1;
        if (above) set_flags[sclf_pkg::FB_MAC0P] = 1'b1;
      end
      sclf_pkg::OP_IR123: begin
        if (below || above) set_flags = chan_flag(sclf_pkg::FB_IR, req.index);
      end
      sclf_pkg::OP_IR0: begin
        if (below || above) set_flags[sclf_pkg::FB_IR0] = 1'b1;
      end
      sclf_pkg::OP_SZ3: begin
        if (below || above) set_flags[sclf_pkg::FB_SZ3] = 1'b1;
      end
      sclf_pkg::OP_RGB: begin
        if (below || above) set_flags = chan_flag(sclf_pkg::FB_RGB, req.index);
      end
      sclf_pkg::OP_SXY2: begin
        // sx and sy only
        if ((below || above) && req.index != sclf_pkg::CH_3)
          set_flags = chan_flag(sclf_pkg::FB_SX2, req.index);
      end
      default: begin
        set_flags = '0;
        shaped    = '0;
      end
    endcase
  end

  assign rsp.shaped_value = shaped;
  assign rsp.flag_word    = base_flags | set_flags;
  assign rsp.saturated    = (req.op != sclf_pkg::OP_UNUSED) && (below || above);

endmodule

>>> src/saturating_clamp_flag_unit.sv
// ----------------------------------------------------------------------------
// saturating_clamp_flag_unit
// Checks a 64-bit signed value against the range of the register its op
// names, wraps or clamps it, and keeps sticky overflow flags.
// ----------------------------------------------------------------------------
// A request is registered into the stage register on acceptance and checked
// there, its response landing in the output register when that register can
// advance. One request is taken every cycle while the response side keeps up.
// The sticky flags update when a request moves into the output register, so
// each response carries the flags as they stand after that request, and
// clear_first clears them before its own check.
module saturating_clamp_flag_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  sclf_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output sclf_pkg::rsp_t  rsp
);

  logic                        stage_valid;
  sclf_pkg::req_t              stage;
  logic [sclf_pkg::FLAG_W-1:0] flags;
  sclf_pkg::rsp_t              result;
  logic                        advance;

  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = !stage_valid || advance;

  sclf_check u_check (
    .req   (stage),
    .flags (flags),
    .rsp   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      stage <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      flags     <= '0;
    end else if (advance) begin
      rsp_valid <= stage_valid;
      if (stage_valid) begin
        flags <= result.flag_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      rsp <= result;
    end
  end

  // flags only grow unless a request clears them
  assert property (@(posedge clk) disable iff (rst)
    (advance && stage_valid && !stage.clear_first) |=>
      ((flags & $past(flags)) == $past(flags)))
    else $error("sticky flag lost without clear");

  // held response always shows the current flags
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.flag_word == flags))
    else $error("response flag word differs from sticky flags");

  // reset leaves no flag and no pending work
  assert property (@(posedge clk)
    rst |=> (flags == '0 && !stage_valid && !rsp_valid))
    else $error("state not cleared by reset");

endmodule
